>>> rtl/bar_strength_reversion_signal_defines.svh
// Assertion macros shared by the checker of bar_strength_reversion_signal.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BAR_STRENGTH_REVERSION_SIGNAL_DEFINES_SVH
`define BAR_STRENGTH_REVERSION_SIGNAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bsr_pkg.sv
// Shared constants and types for the bar strength mean-reversion signal.
// No dependencies; the other source files but the macro header refer to it by scoped names.
`timescale 1ns / 1ps

package bsr_pkg;

	localparam int PRICE_W    = 32;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int COST_W     = 16;
	localparam int TREND_W    = 9;
	localparam int SHORT_W    = 5;
	localparam int HOLD_W     = 8;
	localparam int PROFIT_W   = 33;
	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SHORT_MAX  = 16;
	localparam int SHORT_AW   = $clog2(SHORT_MAX);
	localparam int TREND_MIN  = 16;
	localparam int TSUM_W     = 40;
	localparam int SSUM_W     = 36;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COST      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TREND_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD  = 3'd5;

	// Reset values
	localparam logic [COST_W-1:0]  COST_RST      = 16'd1024;
	localparam logic [LEVEL_W-1:0] IN_LEVEL_RST  = 16'd13107;
	localparam logic [LEVEL_W-1:0] OUT_LEVEL_RST = 16'd45875;
	localparam logic [TREND_W-1:0] TREND_RST     = 9'd200;
	localparam logic [SHORT_W-1:0] SHORT_RST     = 5'd5;
	localparam logic [HOLD_W-1:0]  HOLD_RST      = 8'd10;

	localparam logic [TREND_W-1:0] TREND_LO = TREND_W'(TREND_MIN);
	localparam logic [TREND_W-1:0] TREND_HI = TREND_W'(HIST_DEPTH);
	localparam logic [SHORT_W-1:0] SHORT_LO = 5'd1;
	localparam logic [SHORT_W-1:0] SHORT_HI = SHORT_W'(SHORT_MAX);

	// Strength of a bar with no range: one half in Q0.16
	localparam logic [LEVEL_W-1:0] HALF_LEVEL = 16'd32768;

	// Most negative reportable profit, -2^32
	localparam logic [PROFIT_W-1:0] PROFIT_MIN = {1'b1, {(PROFIT_W-1){1'b0}}};

	typedef struct packed {
		logic [COST_W-1:0]  cost;
		logic [LEVEL_W-1:0] in_level;
		logic [LEVEL_W-1:0] out_level;
		logic [TREND_W-1:0] trend_len;
		logic [SHORT_W-1:0] short_len;
		logic [HOLD_W-1:0]  max_hold;
	} cfg_t;

	typedef struct packed {
		logic str_above;
		logic str_below;
		logic above_short;
		logic above_trend;
	} eval_t;

endpackage

>>> rtl/bar_strength_reversion_signal.sv
// Top level of the bar strength mean-reversion signal.
// Depends on bsr_pkg, bsr_cfg, bsr_hist and bsr_eval.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid/in_stall with one bar (high_price, low_price,
//   close_price, bar_time). A bar is taken at an edge with in_valid high and
//   in_stall low.
//   Output channel: out_valid/out_stall, one result per bar (exit_valid,
//   trade_profit, trade_entry_time, entered, holding, warming_up).
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
//   while no bar is in flight. A write to trend_len or short_len restarts the
//   warm-up and drops any open position.
//   Path: a bar is taken into the input register, then into the result register,
//   where its result is presented and can be taken at the next edge.
//   Throughput: one bar per cycle while out_stall is low. Bars are evaluated in a
//   single stage; the trend window's oldest close comes from a ring RAM read through
//   a register ahead of use, the short window's from a 16-deep shift line.
//   Reset: the valid flags, strategy state and position clear, the ring needs no
//   clearing pass; configuration registers take their default values and warm-up begins.
//   Stall: while out_stall holds a result, one more bar can be taken into the
//   input register; after that in_stall rises until the result is taken.
module bar_strength_reversion_signal (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bsr_pkg::PRICE_W-1:0]       high_price,
	input  logic [bsr_pkg::PRICE_W-1:0]       low_price,
	input  logic [bsr_pkg::PRICE_W-1:0]       close_price,
	input  logic [bsr_pkg::TIME_W-1:0]        bar_time,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              exit_valid,
	output logic signed [bsr_pkg::PROFIT_W-1:0] trade_profit,
	output logic [bsr_pkg::TIME_W-1:0]        trade_entry_time,
	output logic                              entered,
	output logic                              holding,
	output logic                              warming_up,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DIFF_W = bsr_pkg::PROFIT_W + 1;

	bsr_pkg::cfg_t                    cfg;
	bsr_pkg::eval_t                   ev;
	logic                             restart;

	// Input register
	logic                             valid_s1;
	logic [bsr_pkg::PRICE_W-1:0]      high_s1;
	logic [bsr_pkg::PRICE_W-1:0]      low_s1;
	logic [bsr_pkg::PRICE_W-1:0]      close_s1;
	logic [bsr_pkg::TIME_W-1:0]       time_s1;

	// Strategy state
	logic [bsr_pkg::TREND_W-1:0]      bars_seen_q;
	logic [bsr_pkg::TSUM_W-1:0]       trend_sum_q;
	logic [bsr_pkg::SSUM_W-1:0]       short_sum_q;
	logic                             pos_q;
	logic [bsr_pkg::PRICE_W-1:0]      entry_price_q;
	logic [bsr_pkg::TIME_W-1:0]       entry_time_q;
	logic [bsr_pkg::HOLD_W-1:0]       held_q;

	// Result register
	logic                             out_valid_q;
	logic                             exit_q;
	logic [bsr_pkg::PROFIT_W-1:0]     profit_q;
	logic [bsr_pkg::TIME_W-1:0]       exit_time_q;
	logic                             entered_q;
	logic                             holding_q;
	logic                             warm_q;

	logic                             accept;
	logic                             adv;
	logic [bsr_pkg::PRICE_W-1:0]      trend_tap;
	logic [bsr_pkg::PRICE_W-1:0]      short_tap;
	logic                             warm;
	logic [bsr_pkg::PRICE_W-1:0]      old_t;
	logic [bsr_pkg::PRICE_W-1:0]      old_s;
	logic [bsr_pkg::TSUM_W-1:0]       trend_new;
	logic [bsr_pkg::SSUM_W-1:0]       short_new;
	logic [bsr_pkg::HOLD_W-1:0]       held_inc;
	logic                             do_exit;
	logic                             do_enter;
	logic                             pos_d;
	logic [DIFF_W-1:0]                diff;
	logic [bsr_pkg::PROFIT_W-1:0]     profit;

	bsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	// Advance the input register when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			high_s1  <= high_price;
			low_s1   <= low_price;
			close_s1 <= close_price;
			time_s1  <= bar_time;
		end
	end

	bsr_hist u_hist (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (adv),
		.restart     (restart),
		.close_price (close_s1),
		.trend_len   (cfg.trend_len),
		.short_len   (cfg.short_len),
		.trend_tap   (trend_tap),
		.short_tap   (short_tap)
	);

	assign warm  = bars_seen_q < cfg.trend_len;
	assign old_t = warm ? '0 : trend_tap;
	assign old_s = (bars_seen_q >= bsr_pkg::TREND_W'(cfg.short_len)) ? short_tap : '0;

	assign trend_new = trend_sum_q + bsr_pkg::TSUM_W'(close_s1) - bsr_pkg::TSUM_W'(old_t);
	assign short_new = short_sum_q + bsr_pkg::SSUM_W'(close_s1) - bsr_pkg::SSUM_W'(old_s);

	bsr_eval u_eval (
		.high_price  (high_s1),
		.low_price   (low_s1),
		.close_price (close_s1),
		.trend_sum   (trend_new),
		.short_sum   (short_new),
		.cfg         (cfg),
		.res         (ev)
	);

	assign held_inc = held_q + 1'b1;
	assign do_exit  = !warm && pos_q &&
		(ev.str_above || ev.above_short || held_inc >= cfg.max_hold);
	assign do_enter = !warm && (!pos_q || do_exit) && ev.above_trend && ev.str_below;
	assign pos_d    = do_enter || (pos_q && !do_exit);

	// Profit with floor saturation; top bits 10 mean below -2^32
	assign diff = DIFF_W'(close_s1) - DIFF_W'(entry_price_q) - DIFF_W'(cfg.cost);
	assign profit = (diff[DIFF_W-1] && !diff[DIFF_W-2]) ? bsr_pkg::PROFIT_MIN :
		diff[bsr_pkg::PROFIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bars_seen_q   <= '0;
			trend_sum_q   <= '0;
			short_sum_q   <= '0;
			pos_q         <= 1'b0;
			held_q        <= '0;
			entry_price_q <= '0;
			entry_time_q  <= '0;
		end else if (restart) begin
			bars_seen_q <= '0;
			trend_sum_q <= '0;
			short_sum_q <= '0;
			pos_q       <= 1'b0;
			held_q      <= '0;
		end else if (adv) begin
			if (warm) begin
				bars_seen_q <= bars_seen_q + 1'b1;
			end
			trend_sum_q <= trend_new;
			short_sum_q <= short_new;
			pos_q       <= pos_d;
			if (do_enter) begin
				held_q        <= '0;
				entry_price_q <= close_s1;
				entry_time_q  <= time_s1;
			end else if (!warm && pos_q) begin
				held_q <= held_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exit_q      <= do_exit;
			profit_q    <= do_exit ? profit : '0;
			exit_time_q <= do_exit ? entry_time_q : '0;
			entered_q   <= do_enter;
			holding_q   <= pos_d;
			warm_q      <= warm;
		end
	end

	assign out_valid        = out_valid_q;
	assign exit_valid       = exit_q;
	assign trade_profit     = profit_q;
	assign trade_entry_time = exit_time_q;
	assign entered          = entered_q;
	assign holding          = holding_q;
	assign warming_up       = warm_q;

endmodule

>>> rtl/bsr_cfg.sv
// Configuration registers with window saturation on write.
// Depends on bsr_pkg; flags a warm-up restart on a window write.
`timescale 1ns / 1ps

module bsr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output bsr_pkg::cfg_t                      cfg,
	output logic                               restart
);

	bsr_pkg::cfg_t                 cfg_q;
	logic [bsr_pkg::TREND_W-1:0]   trend_raw;
	logic [bsr_pkg::SHORT_W-1:0]   short_raw;
	logic [bsr_pkg::TREND_W-1:0]   trend_sat;
	logic [bsr_pkg::SHORT_W-1:0]   short_sat;
	logic                          wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign trend_raw = cfg_data[bsr_pkg::TREND_W-1:0];
	assign short_raw = cfg_data[bsr_pkg::SHORT_W-1:0];

	// Clamp the windows into their legal ranges
	always_comb begin
		if (trend_raw < bsr_pkg::TREND_LO) begin
			trend_sat = bsr_pkg::TREND_LO;
		end else if (trend_raw > bsr_pkg::TREND_HI) begin
			trend_sat = bsr_pkg::TREND_HI;
		end else begin
			trend_sat = trend_raw;
		end
		if (short_raw < bsr_pkg::SHORT_LO) begin
			short_sat = bsr_pkg::SHORT_LO;
		end else if (short_raw > bsr_pkg::SHORT_HI) begin
			short_sat = bsr_pkg::SHORT_HI;
		end else begin
			short_sat = short_raw;
		end
	end

	assign restart = wr && (cfg_index == bsr_pkg::REG_TREND_LEN ||
		cfg_index == bsr_pkg::REG_SHORT_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cost      <= bsr_pkg::COST_RST;
			cfg_q.in_level  <= bsr_pkg::IN_LEVEL_RST;
			cfg_q.out_level <= bsr_pkg::OUT_LEVEL_RST;
			cfg_q.trend_len <= bsr_pkg::TREND_RST;
			cfg_q.short_len <= bsr_pkg::SHORT_RST;
			cfg_q.max_hold  <= bsr_pkg::HOLD_RST;
		end else if (wr) begin
			case (cfg_index)
				bsr_pkg::REG_COST:      cfg_q.cost      <= cfg_data[bsr_pkg::COST_W-1:0];
				bsr_pkg::REG_IN_LEVEL:  cfg_q.in_level  <= cfg_data[bsr_pkg::LEVEL_W-1:0];
				bsr_pkg::REG_OUT_LEVEL: cfg_q.out_level <= cfg_data[bsr_pkg::LEVEL_W-1:0];
				bsr_pkg::REG_TREND_LEN: cfg_q.trend_len <= trend_sat;
				bsr_pkg::REG_SHORT_LEN: cfg_q.short_len <= short_sat;
				bsr_pkg::REG_MAX_HOLD:  cfg_q.max_hold  <= cfg_data[bsr_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bsr_hist.sv
// Close history: ring memory for the trend tap, shift line for the short tap.
// Depends on bsr_pkg. The trend tap is a registered read, addressed ahead of its use.
`timescale 1ns / 1ps

module bsr_hist (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             restart,
	input  logic [bsr_pkg::PRICE_W-1:0]      close_price,
	input  logic [bsr_pkg::TREND_W-1:0]      trend_len,
	input  logic [bsr_pkg::SHORT_W-1:0]      short_len,
	output logic [bsr_pkg::PRICE_W-1:0]      trend_tap,
	output logic [bsr_pkg::PRICE_W-1:0]      short_tap
);

	logic [bsr_pkg::PRICE_W-1:0]  ring_mem [bsr_pkg::HIST_DEPTH];
	logic [bsr_pkg::PRICE_W-1:0]  recent_q [bsr_pkg::SHORT_MAX];
	logic [bsr_pkg::HIST_AW-1:0]  wp_q;
	logic [bsr_pkg::HIST_AW-1:0]  wp_d;
	logic [bsr_pkg::HIST_AW-1:0]  rd_addr;
	logic [bsr_pkg::SHORT_W-1:0]  short_m1;

	always_comb begin
		if (restart) begin
			wp_d = '0;
		end else if (push) begin
			wp_d = wp_q + 1'b1;
		end else begin
			wp_d = wp_q;
		end
	end

	// Address the oldest trend entry of the next request; a full-depth window wraps onto wp
	assign rd_addr = wp_d - trend_len[bsr_pkg::HIST_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else begin
			wp_q <= wp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[wp_q] <= close_price;
		end
		trend_tap <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			recent_q[0] <= close_price;
			for (int i = 1; i < bsr_pkg::SHORT_MAX; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

	assign short_m1  = short_len - 1'b1;
	assign short_tap = recent_q[short_m1[bsr_pkg::SHORT_AW-1:0]];

endmodule

>>> rtl/bsr_eval.sv
// Exact cross-multiplied comparisons of bar strength and of the close
// against both moving averages. Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_eval (
	input  logic [bsr_pkg::PRICE_W-1:0]  high_price,
	input  logic [bsr_pkg::PRICE_W-1:0]  low_price,
	input  logic [bsr_pkg::PRICE_W-1:0]  close_price,
	input  logic [bsr_pkg::TSUM_W-1:0]   trend_sum,
	input  logic [bsr_pkg::SSUM_W-1:0]   short_sum,
	input  bsr_pkg::cfg_t                cfg,
	output bsr_pkg::eval_t               res
);

	localparam int PROD_W  = bsr_pkg::PRICE_W + bsr_pkg::LEVEL_W;
	localparam int TPROD_W = bsr_pkg::PRICE_W + bsr_pkg::TREND_W;
	localparam int SPROD_W = bsr_pkg::PRICE_W + bsr_pkg::SHORT_W;

	logic                          has_range;
	logic                          close_low;
	logic [bsr_pkg::PRICE_W-1:0]   cl;
	logic [bsr_pkg::PRICE_W-1:0]   hl;
	logic [PROD_W-1:0]             cl_scaled;
	logic [PROD_W-1:0]             out_prod;
	logic [PROD_W-1:0]             in_prod;
	logic [TPROD_W-1:0]            trend_prod;
	logic [SPROD_W-1:0]            short_prod;

	assign has_range = high_price > low_price;
	assign close_low = close_price < low_price;
	assign cl        = close_price - low_price;
	assign hl        = high_price - low_price;
	assign cl_scaled = {cl, {bsr_pkg::LEVEL_W{1'b0}}};
	assign out_prod  = PROD_W'(cfg.out_level) * PROD_W'(hl);
	assign in_prod   = PROD_W'(cfg.in_level) * PROD_W'(hl);
	assign trend_prod = TPROD_W'(close_price) * TPROD_W'(cfg.trend_len);
	assign short_prod = SPROD_W'(close_price) * SPROD_W'(cfg.short_len);

	always_comb begin
		if (!has_range) begin
			res.str_above = bsr_pkg::HALF_LEVEL > cfg.out_level;
			res.str_below = bsr_pkg::HALF_LEVEL < cfg.in_level;
		end else if (close_low) begin
			// negative strength
			res.str_above = 1'b0;
			res.str_below = 1'b1;
		end else begin
			res.str_above = cl_scaled > out_prod;
			res.str_below = cl_scaled < in_prod;
		end
		res.above_trend = trend_prod > TPROD_W'(trend_sum);
		res.above_short = short_prod > SPROD_W'(short_sum);
	end

endmodule

>>> rtl/bsr_checker.sv
// Port-level checker for bar_strength_reversion_signal, bound to the top level.
// Depends on bsr_pkg and bar_strength_reversion_signal_defines.svh.
`timescale 1ns / 1ps
`include "bar_strength_reversion_signal_defines.svh"

module bsr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              exit_valid,
	input  logic signed [bsr_pkg::PROFIT_W-1:0] trade_profit,
	input  logic [bsr_pkg::TIME_W-1:0]        trade_entry_time,
	input  logic                              entered,
	input  logic                              holding,
	input  logic                              warming_up
);

	// Hold a stalled result: exit, profit, entry time and position stay
	`BSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(exit_valid) && $stable(trade_profit) && $stable(trade_entry_time) && $stable(holding), "stalled result changed")

	// No trading while warming up
	`BSR_ASSERT_NOW(a_warm_quiet, out_valid && warming_up, !exit_valid && !entered, "trade reported during warm-up")

	// Position after a trade event follows the entry flag
	`BSR_ASSERT_NOW(a_pos_flag, out_valid && (exit_valid || entered), holding == entered, "position flag inconsistent with trade events")

	// Trade fields are zero without an exit
	`BSR_ASSERT_NOW(a_zero_fields, out_valid && !exit_valid, trade_profit == '0 && trade_entry_time == '0, "trade fields set without exit")

endmodule

bind bar_strength_reversion_signal bsr_checker u_bsr_checker (.*);

>>> tb/sv/bar_strength_reversion_signal_test.sv
// Self-checking testbench for bar_strength_reversion_signal: bars are driven through the
// valid/stall channel and each result is checked against a predictor kept here.
// Depends on bsr_pkg and the bar_strength_reversion_signal RTL.
`timescale 1ns / 1ps

module bar_strength_reversion_signal_test;

	localparam int          CYCLE_LIMIT = 600000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          NUM_REGS    = 6;
	localparam int          REPORT_MAX  = 40;
	localparam longint      PNL_MIN     = -64'sd4294967296;
	localparam longint      PNL_MAX     = 64'sd4294967295;
	localparam logic [31:0] PRICE_TOP   = 32'hFFFF_FFFF;

	localparam logic [NUM_REGS-1:0] ALL_REGS   = '1;
	localparam logic [NUM_REGS-1:0] LEVEL_REGS = (NUM_REGS'(1) << bsr_pkg::REG_COST)
		| (NUM_REGS'(1) << bsr_pkg::REG_IN_LEVEL) | (NUM_REGS'(1) << bsr_pkg::REG_OUT_LEVEL)
		| (NUM_REGS'(1) << bsr_pkg::REG_MAX_HOLD);
	localparam logic [NUM_REGS-1:0] SHORT_REG  = NUM_REGS'(1) << bsr_pkg::REG_SHORT_LEN;

	typedef struct packed {
		logic [bsr_pkg::PRICE_W-1:0] high;
		logic [bsr_pkg::PRICE_W-1:0] low;
		logic [bsr_pkg::PRICE_W-1:0] close;
		logic [bsr_pkg::TIME_W-1:0]  stamp;
	} bar_t;

	typedef struct packed {
		logic                                exited;
		logic signed [bsr_pkg::PROFIT_W-1:0] profit;
		logic [bsr_pkg::TIME_W-1:0]          entry_stamp;
		logic                                opened;
		logic                                holding;
		logic                                warming;
	} signal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bsr_pkg::PRICE_W-1:0] high_price = '0;
	logic [bsr_pkg::PRICE_W-1:0] low_price = '0;
	logic [bsr_pkg::PRICE_W-1:0] close_price = '0;
	logic [bsr_pkg::TIME_W-1:0] bar_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic exit_valid;
	logic signed [bsr_pkg::PROFIT_W-1:0] trade_profit;
	logic [bsr_pkg::TIME_W-1:0] trade_entry_time;
	logic entered;
	logic holding;
	logic warming_up;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: its own copy of the registers, the close history and the position
	bsr_pkg::cfg_t regs = '{bsr_pkg::COST_RST, bsr_pkg::IN_LEVEL_RST, bsr_pkg::OUT_LEVEL_RST,
		bsr_pkg::TREND_RST, bsr_pkg::SHORT_RST, bsr_pkg::HOLD_RST};
	logic [bsr_pkg::PRICE_W-1:0] closes [bsr_pkg::HIST_DEPTH];
	logic [bsr_pkg::HIST_AW-1:0] slot = '0;
	logic [bsr_pkg::TREND_W-1:0] stored = '0;
	logic [bsr_pkg::TSUM_W-1:0]  trend_total = '0;
	logic [bsr_pkg::SSUM_W-1:0]  short_total = '0;
	logic                        long_open = 1'b0;
	logic [bsr_pkg::PRICE_W-1:0] open_price = '0;
	logic [bsr_pkg::TIME_W-1:0]  open_stamp = '0;
	logic [bsr_pkg::HOLD_W-1:0]  held_bars = '0;

	signal_t signals_due [$];

	logic [31:0] walk = 32'd25600;
	logic [31:0] stamp = '0;
	int gap_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_used = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int bars_sent = 0;
	int results_seen = 0;
	int entries = 0;
	int exits = 0;
	int reg_writes = 0;
	int mismatches = 0;

	bar_strength_reversion_signal dut (
		.clk, .arst_n, .in_valid, .in_stall, .high_price, .low_price, .close_price, .bar_time,
		.out_valid, .out_stall, .exit_valid, .trade_profit, .trade_entry_time, .entered,
		.holding, .warming_up, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sign of (strength - level/65536), by cross-multiplication
	function automatic int strength_vs(input bar_t b, input logic [bsr_pkg::LEVEL_W-1:0] level);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (b.high <= b.low)
			return (bsr_pkg::HALF_LEVEL > level) ? 1 : (bsr_pkg::HALF_LEVEL < level) ? -1 : 0;
		if (b.close < b.low)
			return -1;
		lhs = 64'(b.close - b.low) << 16;
		rhs = 64'(level) * 64'(b.high - b.low);
		return (lhs > rhs) ? 1 : (lhs < rhs) ? -1 : 0;
	endfunction

	function automatic signal_t step_strategy(input bar_t b);
		signal_t s;
		int unsigned tl;
		int unsigned sl;
		logic warm;
		logic [bsr_pkg::PRICE_W-1:0] old_t;
		logic [bsr_pkg::PRICE_W-1:0] old_s;
		longint pnl;
		s = '0;
		tl = (regs.trend_len < bsr_pkg::TREND_MIN) ? bsr_pkg::TREND_MIN :
			(regs.trend_len > bsr_pkg::HIST_DEPTH) ? bsr_pkg::HIST_DEPTH : regs.trend_len;
		sl = (regs.short_len < 1) ? 1 :
			(regs.short_len > bsr_pkg::SHORT_MAX) ? bsr_pkg::SHORT_MAX : regs.short_len;
		warm = stored < tl;
		// drop the closes leaving each window before the slot is overwritten
		old_t = (stored >= tl) ? closes[bsr_pkg::HIST_AW'(slot - tl)] : '0;
		old_s = (stored >= sl) ? closes[bsr_pkg::HIST_AW'(slot - sl)] : '0;
		trend_total = trend_total + b.close - old_t;
		short_total = short_total + b.close - old_s;
		closes[slot] = b.close;
		slot = slot + 1'b1;
		if (warm)
			stored = stored + 1'b1;
		if (!warm) begin
			if (long_open) begin
				held_bars = held_bars + 1'b1;
				if (strength_vs(b, regs.out_level) > 0 || 64'(b.close) * sl > 64'(short_total)
						|| held_bars >= regs.max_hold) begin
					pnl = longint'(b.close) - longint'(open_price) - longint'(regs.cost);
					if (pnl < PNL_MIN)
						pnl = PNL_MIN;
					if (pnl > PNL_MAX)
						pnl = PNL_MAX;
					s.exited = 1'b1;
					s.profit = bsr_pkg::PROFIT_W'(pnl);
					s.entry_stamp = open_stamp;
					long_open = 1'b0;
					exits++;
				end
			end
			if (!long_open && 64'(b.close) * tl > 64'(trend_total)
					&& strength_vs(b, regs.in_level) < 0) begin
				long_open = 1'b1;
				open_price = b.close;
				open_stamp = b.stamp;
				held_bars = '0;
				s.opened = 1'b1;
				entries++;
			end
		end
		s.holding = long_open;
		s.warming = warm;
		return s;
	endfunction

	function automatic logic [31:0] clamp_price(input longint v);
		if (v < 0)
			return '0;
		if (v > longint'(PRICE_TOP))
			return PRICE_TOP;
		return 32'(v);
	endfunction

	// Random-walk bar with a slight upward drift, closes often near the low; a few bars are
	// pure noise, have no range, or close under the low
	function automatic bar_t make_bar();
		bar_t b;
		longint span;
		longint c;
		longint lo;
		longint rng;
		int unsigned kind;
		kind = $urandom_range(99);
		stamp = stamp + $urandom_range(1, 900);
		if (kind < 6) begin
			b.high = $urandom;
			b.low = $urandom;
			b.close = $urandom;
			b.stamp = $urandom;
			return b;
		end
		span = longint'(walk >> 7) + 256;
		c = clamp_price(longint'(walk) + longint'($urandom_range(0, 32'(span))) - span / 2
			+ span / 12);
		walk = 32'(c);
		rng = longint'($urandom_range(0, 32'(span)));
		b.stamp = stamp;
		b.close = 32'(c);
		if (kind < 10) begin
			b.low = clamp_price(c + longint'($urandom_range(0, 32'(rng))));
			b.high = clamp_price(longint'(b.low) - longint'($urandom_range(0, 32'(rng))));
		end else if (kind < 14) begin
			lo = c + 1 + longint'($urandom_range(0, 32'(rng)));
			b.low = clamp_price(lo);
			b.high = clamp_price(lo + 1 + rng);
		end else begin
			lo = c - longint'($urandom_range(0, 32'((kind < 55) ? rng / 8 : rng)));
			b.low = clamp_price(lo);
			b.high = clamp_price(lo + rng);
		end
		return b;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s mismatch on result %0d: got %0d, want %0d",
				$realtime, field, results_seen, got, want);
	endtask

	task automatic send_bar(input bar_t b);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		// hold the request until the block takes it
		in_valid <= 1'b1;
		high_price <= b.high;
		low_price <= b.low;
		close_price <= b.close;
		bar_time <= b.stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		signals_due = {signals_due, step_strategy(b)};
		bars_sent++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (signals_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write the registers flagged in which, lowest index first; only called while idle
	task automatic program_regs(input logic [NUM_REGS-1:0] which, input bsr_pkg::cfg_t v);
		logic [bsr_pkg::CFG_IDX_W-1:0] idx;
		logic [bsr_pkg::CFG_DATA_W-1:0] data;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (which[i]) begin
				idx = bsr_pkg::CFG_IDX_W'(i);
				data = '0;
				case (idx)
					bsr_pkg::REG_COST: begin
						data = v.cost;
						regs.cost = v.cost;
					end
					bsr_pkg::REG_IN_LEVEL: begin
						data = v.in_level;
						regs.in_level = v.in_level;
					end
					bsr_pkg::REG_OUT_LEVEL: begin
						data = v.out_level;
						regs.out_level = v.out_level;
					end
					bsr_pkg::REG_TREND_LEN: begin
						data = bsr_pkg::CFG_DATA_W'(v.trend_len);
						regs.trend_len = v.trend_len;
					end
					bsr_pkg::REG_SHORT_LEN: begin
						data = bsr_pkg::CFG_DATA_W'(v.short_len);
						regs.short_len = v.short_len;
					end
					bsr_pkg::REG_MAX_HOLD: begin
						data = bsr_pkg::CFG_DATA_W'(v.max_hold);
						regs.max_hold = v.max_hold;
					end
					default: data = '0;
				endcase
				// a window write restarts the warm-up and drops the open trade
				if (idx == bsr_pkg::REG_TREND_LEN || idx == bsr_pkg::REG_SHORT_LEN) begin
					slot = '0;
					stored = '0;
					trend_total = '0;
					short_total = '0;
					long_open = 1'b0;
					held_bars = '0;
				end
				cfg_valid <= 1'b1;
				cfg_index <= idx;
				cfg_data <= data;
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
				reg_writes++;
			end
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_bar('{32'd0, 32'd0, 32'd0, 32'd0});
		send_bar('{PRICE_TOP, PRICE_TOP, PRICE_TOP, PRICE_TOP});
		send_bar('{32'd100, 32'd200, 32'd150, 32'd7});
	endtask

	// Shortest trend window and longest short window by saturation, zero max_hold, widest cost and levels
	task automatic test_edge_trades();
		wait_quiet();
		program_regs(ALL_REGS, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0, 5'd31, 8'd0});
		for (int i = 0; i < bsr_pkg::TREND_MIN; i++) begin
			stamp = stamp + 60;
			send_bar('{32'd9000 + 32'(i), 32'd7000, 32'd8000 + 32'(i), stamp});
		end
		// close under the low near the top of the range: enter
		send_bar('{PRICE_TOP, PRICE_TOP - 1, PRICE_TOP - 2, PRICE_TOP});
		// exit at zero: the loss saturates
		send_bar('{32'd0, 32'd0, 32'd0, 32'd0});
		// inverted bar, strength one half: enter
		send_bar('{32'd5, 32'd6, 32'hF000_0000, 32'd12345});
		// full-strength bar: exit in profit
		send_bar('{PRICE_TOP, 32'd0, PRICE_TOP, 32'd12346});
	endtask

	task automatic test_window_change();
		send_bar('{PRICE_TOP, PRICE_TOP - 16, PRICE_TOP - 32, 32'hA5A5_5A5A});
		wait_quiet();
		program_regs(SHORT_REG, '{16'd0, 16'd0, 16'd0, 9'd16, 5'd1, 8'd1});
		send_bar('{32'd3000, 32'd1000, 32'd2000, 32'd1});
		send_bar('{32'd3000, 32'd1000, 32'd1200, 32'd2});
	endtask

	task automatic test_random_trading(input int bars, input logic [bsr_pkg::TREND_W-1:0] trend,
			input logic [bsr_pkg::SHORT_W-1:0] window, input int send_gap, input int recv_stall);
		bsr_pkg::cfg_t v;
		wait_quiet();
		v.cost = 16'($urandom_range(0, 16'hFFFF));
		v.in_level = 16'($urandom_range(8192, 52000));
		v.out_level = 16'($urandom_range(32768, 16'hFFFF));
		v.trend_len = trend;
		v.short_len = window;
		v.max_hold = 8'($urandom_range(1, 24));
		program_regs(ALL_REGS, v);
		gap_pct = send_gap;
		stall_pct <= recv_stall;
		walk = $urandom_range(1024, 32'h3FFF_FFFF);
		repeat (bars) send_bar(make_bar());
	endtask

	// Level and hold extremes on a warmed history, without restarting the warm-up
	task automatic test_level_extremes();
		wait_quiet();
		program_regs(LEVEL_REGS, '{16'd0, 16'd0, 16'd0, 9'd0, 5'd0, 8'd255});
		gap_pct = 22;
		stall_pct <= 22;
		repeat (75) send_bar(make_bar());
		wait_quiet();
		program_regs(LEVEL_REGS, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0, 5'd0, 8'd0});
		repeat (75) send_bar(make_bar());
	endtask

	// Receiver holds off while bars keep coming, so the block backs up and stalls its input
	task automatic test_output_pressure();
		bsr_pkg::cfg_t v;
		wait_quiet();
		v = '{16'd256, 16'd30000, 16'd50000, 9'd20, 5'd3, 8'd6};
		program_regs(ALL_REGS, v);
		gap_pct = 0;
		stall_pct <= 0;
		hold_req <= 1'b1;
		repeat (60) send_bar(make_bar());
	endtask

	// Long hold-off, counted in its own process
	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : result_check
		signal_t got;
		signal_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{exit_valid, trade_profit, trade_entry_time, entered, holding, warming_up};
			if (signals_due.size() == 0) begin
				report_mismatch("unexpected result, exit_valid", longint'(got.exited), 0);
			end else begin
				want = signals_due.pop_front();
				if (got.exited !== want.exited)
					report_mismatch("exit_valid", longint'(got.exited), longint'(want.exited));
				if (got.profit !== want.profit)
					report_mismatch("trade_profit", longint'(got.profit), longint'(want.profit));
				if (got.entry_stamp !== want.entry_stamp)
					report_mismatch("trade_entry_time", longint'(got.entry_stamp),
						longint'(want.entry_stamp));
				if (got.opened !== want.opened)
					report_mismatch("entered", longint'(got.opened), longint'(want.opened));
				if (got.holding !== want.holding)
					report_mismatch("holding", longint'(got.holding), longint'(want.holding));
				if (got.warming !== want.warming)
					report_mismatch("warming_up", longint'(got.warming), longint'(want.warming));
			end
			results_seen++;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				signals_due.size());
			$display("bar_strength_reversion_signal test failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_edge_trades();
		test_window_change();
		test_random_trading(220, 9'd16, 5'd1, 0, 0);
		test_random_trading(220, 9'($urandom_range(16, 48)), 5'($urandom_range(1, 16)), 83, 0);
		test_random_trading(220, 9'($urandom_range(16, 48)), 5'($urandom_range(1, 16)), 0, 83);
		test_random_trading(220, 9'($urandom_range(16, 48)), 5'($urandom_range(1, 16)), 22, 22);
		test_random_trading(400, 9'd511, 5'd31, 0, 0);
		test_level_extremes();
		test_output_pressure();
		test_random_trading(200, 9'd17, 5'd16, 83, 83);
		wait_quiet();
		repeat (4) @(posedge clk);
		$display("bars %0d, results checked %0d, register writes %0d", bars_sent, results_seen,
			reg_writes);
		$display("trades opened %0d, closed %0d, mismatches %0d", entries, exits, mismatches);
		if (mismatches == 0 && signals_due.size() == 0) begin
			$display("bar_strength_reversion_signal test passed");
		end else begin
			$display("bar_strength_reversion_signal test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/bsr_pkg.sv
rtl/bsr_cfg.sv
rtl/bsr_hist.sv
rtl/bsr_eval.sv
rtl/bar_strength_reversion_signal.sv
rtl/bsr_checker.sv
tb/sv/bar_strength_reversion_signal_test.sv
